// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam logic [1:0] OP_ALLOC       = 2'd0;
  localparam logic [1:0] OP_FREE        = 2'd1;
  localparam logic [1:0] OP_FREE_REGION = 2'd2;
  localparam logic [1:0] OP_RESERVE     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       alloc;
    logic       set_bits;
    logic [4:0] lo_bit;
    logic [4:0] hi_bit;
  } bfa_wctl_t;

  typedef struct packed {
    logic       found;
    logic [4:0] bit_idx;
  } bfa_wres_t;

endpackage

// File: rtl/core/bfa_word_unit.sv
// ----------------------------------------------------------------------------
// bfa_word_unit
// Read-modify-write unit for one bitmap word: finds and sets the lowest
// clear bit, or sets or clears a contiguous span of bits.
// ----------------------------------------------------------------------------
module bfa_word_unit (
  input  logic [31:0]          word_i,
  input  bfa_pkg::bfa_wctl_t   ctl_i,
  output logic [31:0]          word_o,
  output bfa_pkg::bfa_wres_t   res_o
);

  logic [31:0] inv;
  logic [31:0] low1;
  logic [31:0] span;
  logic [4:0]  idx;

  always_comb begin
    inv  = ~word_i;
    low1 = inv & (~inv + 32'd1);
    span = (bfa_pkg::WORD_FULL << ctl_i.lo_bit) &
           (bfa_pkg::WORD_FULL >> (5'd31 - ctl_i.hi_bit));
    idx  = 5'd0;
    for (int j = 0; j < 32; j++) begin
      if (low1[j]) begin
        idx = idx | 5'(j);
      end
    end
    priority if (ctl_i.alloc) begin
      word_o = word_i | low1;
    end else if (ctl_i.set_bits) begin
      word_o = word_i | span;
    end else begin
      word_o = word_i & ~span;
    end
    res_o.found   = (word_i != bfa_pkg::WORD_FULL);
    res_o.bit_idx = idx;
  end

endmodule

// File: rtl/core/bitmap_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit page frame allocator over a used/free bitmap held in a memory.
// ----------------------------------------------------------------------------
// The bitmap lives in a memory of WORD_COUNT words of 32 bits, read and
// written one word per step through a single read-modify-write unit. After
// reset the block fills the memory with ones (every frame used), with
// in_tready low. An alloc visits words in order, reading each word and
// then either setting its lowest clear bit or moving on, and reports
// ST_NO_FREE after the last word. A single free reads and clears one bit,
// or skips the bitmap when its address is beyond the frame count. A region
// operation sums, rounds and clamps its bounds, then reads and writes each
// bitmap word it touches. One operation is in work at a time; the next
// transfer is taken as soon as the result is in the output register, even
// while that result still waits. A finished operation waits until the
// output register is free, that is until the previous result has been
// transferred.
module bitmap_frame_allocator_unit #(
  parameter int WORD_COUNT = 128,
  parameter int PAGE_SHIFT = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // free_address[31:0], region_base[95:32],
                                   // region_length[159:96]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // frame_address[31:0]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int FW = WW + 5;
  localparam int RW = 65 - PAGE_SHIFT;
  localparam int PW = (FW + PAGE_SHIFT > 32) ? (FW + PAGE_SHIFT) : 32;
  localparam logic [FW:0] FRAME_TOTAL = (FW + 1)'(WORD_COUNT * 32);
  localparam logic [WW-1:0] LAST_WORD = WW'(WORD_COUNT - 1);
  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_ROUND = 4'd4;
  localparam logic [3:0] S_CLAMP = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_MOD   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [63:0]   len_r, len_nxt;
  logic [63:0]   end_r, end_nxt;
  logic [RW-1:0] lo_r, lo_nxt;
  logic [RW-1:0] hi_r, hi_nxt;
  logic [FW:0]   hic_r, hic_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic [WW-1:0] last_r, last_nxt;
  logic [4:0]    lo_bit_r, lo_bit_nxt;
  logic [4:0]    hi_bit_r, hi_bit_nxt;
  logic          first_r, first_nxt;
  logic [31:0]   res_fa_r, res_fa_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_fa_r, out_fa_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  logic [31:0]   mem [WORD_COUNT];
  logic [31:0]   rdata_r;
  logic          mem_we;
  logic [31:0]   mem_wdata;

  bfa_pkg::bfa_wctl_t wctl;
  bfa_pkg::bfa_wres_t wres;
  logic [31:0]        wnew;

  logic [31:0]   free_frame;
  logic [RW-1:0] base_fl, base_cl, end_fl, end_cl;
  logic [FW:0]   hi_last;
  logic [FW-1:0] alloc_frame;
  logic [PW-1:0] alloc_prod;
  logic          load_out;

  bfa_word_unit u_word (
    .word_i (rdata_r),
    .ctl_i  (wctl),
    .word_o (wnew),
    .res_o  (wres)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= mem_wdata;
    end
    rdata_r <= mem[word_r];
  end

  always_comb begin
    wctl.alloc    = (op_r == bfa_pkg::OP_ALLOC);
    wctl.set_bits = (op_r == bfa_pkg::OP_RESERVE);
    wctl.lo_bit   = first_r ? lo_bit_r : 5'd0;
    wctl.hi_bit   = (word_r == last_r) ? hi_bit_r : 5'd31;

    free_frame  = addr_r >> PAGE_SHIFT;
    base_fl     = RW'(base_r >> PAGE_SHIFT);
    base_cl     = base_fl + RW'((base_r & PAGE_MASK) != 64'd0);
    end_fl      = RW'(end_r >> PAGE_SHIFT);
    end_cl      = end_fl + RW'((end_r & PAGE_MASK) != 64'd0);
    hi_last     = hic_r - (FW + 1)'(1);
    alloc_frame = {word_r, wres.bit_idx};
    alloc_prod  = PW'(alloc_frame) << PAGE_SHIFT;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    end_nxt    = end_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    hic_nxt    = hic_r;
    word_nxt   = word_r;
    last_nxt   = last_r;
    lo_bit_nxt = lo_bit_r;
    hi_bit_nxt = hi_bit_r;
    first_nxt  = first_r;
    res_fa_nxt = res_fa_r;
    res_st_nxt = res_st_r;
    mem_we     = 1'b0;
    mem_wdata  = wnew;
    in_tready  = 1'b0;
    load_out   = 1'b0;

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = bfa_pkg::WORD_FULL;
        if (word_r == LAST_WORD) begin
          word_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          word_nxt = word_r + WW'(1);
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          addr_nxt  = in_tdata[31:0];
          base_nxt  = in_tdata[95:32];
          len_nxt   = in_tdata[159:96];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_fa_nxt = '0;
        res_st_nxt = bfa_pkg::ST_OK;
        first_nxt  = 1'b1;
        unique case (op_r)
          bfa_pkg::OP_ALLOC: begin
            word_nxt  = '0;
            last_nxt  = LAST_WORD;
            state_nxt = S_RD;
          end
          bfa_pkg::OP_FREE: begin
            if (free_frame >= 32'(FRAME_TOTAL)) begin
              res_st_nxt = bfa_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              word_nxt   = free_frame[FW-1:5];
              last_nxt   = free_frame[FW-1:5];
              lo_bit_nxt = free_frame[4:0];
              hi_bit_nxt = free_frame[4:0];
              state_nxt  = S_RD;
            end
          end
          default: begin
            state_nxt = S_SUM;
          end
        endcase
      end
      S_SUM: begin
        end_nxt   = base_r + len_r;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (op_r == bfa_pkg::OP_FREE_REGION) begin
          lo_nxt = base_cl;
          hi_nxt = end_fl;
        end else begin
          lo_nxt = base_fl;
          hi_nxt = end_cl;
        end
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        hic_nxt   = (hi_r > RW'(FRAME_TOTAL)) ? FRAME_TOTAL : hi_r[FW:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (lo_r < RW'(hic_r)) begin
          word_nxt   = lo_r[FW-1:5];
          lo_bit_nxt = lo_r[4:0];
          last_nxt   = hi_last[FW-1:5];
          hi_bit_nxt = hi_last[4:0];
          state_nxt  = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (op_r == bfa_pkg::OP_ALLOC) begin
          if (wres.found) begin
            mem_we     = 1'b1;
            res_fa_nxt = alloc_prod[31:0];
            state_nxt  = S_DONE;
          end else if (word_r == last_r) begin
            res_st_nxt = bfa_pkg::ST_NO_FREE;
            state_nxt  = S_DONE;
          end else begin
            word_nxt  = word_r + WW'(1);
            state_nxt = S_RD;
          end
        end else begin
          mem_we = 1'b1;
          if (word_r == last_r) begin
            state_nxt = S_DONE;
          end else begin
            word_nxt  = word_r + WW'(1);
            first_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    out_fa_nxt    = out_fa_r;
    out_st_nxt    = out_st_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_fa_nxt    = res_fa_r;
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    base_r   <= base_nxt;
    len_r    <= len_nxt;
    end_r    <= end_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    hic_r    <= hic_nxt;
    last_r   <= last_nxt;
    lo_bit_r <= lo_bit_nxt;
    hi_bit_r <= hi_bit_nxt;
    first_r  <= first_nxt;
    res_fa_r <= res_fa_nxt;
    res_st_r <= res_st_nxt;
    out_fa_r <= out_fa_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_fa_r;
  assign out_tuser  = out_st_r;

endmodule

// File: rtl/core/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the bitmap frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result changed before its transfer.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input was ready again right after a transfer.");

  a_zero_address_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bfa_pkg::ST_OK |-> out_tdata == 32'd0)
    else $error("Failed operation returned a nonzero frame address.");

  a_fill_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready && !out_tvalid)
    else $error("Block was ready or showed a result during the bitmap fill.");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_tb_checker
// Watches both streams of the frame allocator, keeps its own copy of the
// used/free bitmap, predicts one result per accepted operation and compares
// every result transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_tb_checker #(
  parameter int WORD_COUNT = 128,
  parameter int PAGE_SHIFT = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,   // free_address[31:0], region_base[95:32],
                                   // region_length[159:96]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,  // frame_address[31:0]
  input  logic [1:0]   out_tuser,  // status[1:0]
  output int           fail_count,
  output int           pending
);

  localparam logic [63:0] FRAME_TOTAL = 64'(WORD_COUNT) * 64'd32;
  localparam logic [63:0] PAGE_MASK   = (64'd1 << PAGE_SHIFT) - 64'd1;

  typedef struct packed {
    logic [31:0] frame_address;
    logic [1:0]  status;
  } frame_result_t;

  logic [31:0]   used_map [WORD_COUNT];
  frame_result_t frame_result_q [$];
  int            result_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
             $time, result_count, what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] page_up(input logic [63:0] a);
    return (a >> PAGE_SHIFT) + ((a & PAGE_MASK) != 64'd0 ? 64'd1 : 64'd0);
  endfunction

  function automatic void mark_frames(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic used);
    logic [63:0] f;
    if (hi > FRAME_TOTAL) hi = FRAME_TOTAL;
    for (f = lo; f < hi; f++) used_map[f >> 5][f[4:0]] = used;
  endfunction

  function automatic frame_result_t predict_frame_op(input logic [1:0] op,
                                                     input logic [31:0] addr,
                                                     input logic [63:0] base,
                                                     input logic [63:0] len);
    frame_result_t r;
    logic [63:0]   stop;
    logic [63:0]   fno;
    bit            found;
    int            w;
    int            b;
    r.frame_address = 32'd0;
    r.status = bfa_pkg::ST_OK;
    found = 1'b0;
    stop = base + len;
    case (op)
      bfa_pkg::OP_ALLOC: begin
        for (w = 0; w < WORD_COUNT && !found; w++) begin
          for (b = 0; b < 32 && !found; b++) begin
            if (!used_map[w][b]) begin
              used_map[w][b] = 1'b1;
              fno = 64'(w) * 64'd32 + 64'(b);
              r.frame_address = 32'(fno << PAGE_SHIFT);
              found = 1'b1;
            end
          end
        end
        if (!found) r.status = bfa_pkg::ST_NO_FREE;
      end
      bfa_pkg::OP_FREE: begin
        fno = 64'(addr >> PAGE_SHIFT);
        if (fno >= FRAME_TOTAL) r.status = bfa_pkg::ST_RANGE;
        else used_map[fno >> 5][fno[4:0]] = 1'b0;
      end
      bfa_pkg::OP_FREE_REGION: mark_frames(page_up(base), stop >> PAGE_SHIFT, 1'b0);
      default: mark_frames(base >> PAGE_SHIFT, page_up(stop), 1'b1);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      for (int w = 0; w < WORD_COUNT; w++) used_map[w] = bfa_pkg::WORD_FULL;
      frame_result_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_result_q.size() == 0) begin
          report("arrived with nothing outstanding", out_tdata, 32'(out_tuser));
        end else begin
          want = frame_result_q.pop_front();
          if (out_tdata !== want.frame_address)
            report("frame_address", out_tdata, want.frame_address);
          if (out_tuser !== want.status)
            report("status", 32'(out_tuser), 32'(want.status));
        end
        result_count++;
      end
      if (in_tvalid && in_tready)
        frame_result_q.push_back(predict_frame_op(in_tuser, in_tdata[31:0],
                                                  in_tdata[95:32], in_tdata[159:96]));
    end
    pending = frame_result_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives alloc, free, free-region and reserve-region operations into the
// frame allocator with bursty input and a stalling result side, and gives
// the verdict from the failure count of the checker or from a stall limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_COUNT   = 128;
  localparam int PAGE_SHIFT   = 12;
  localparam int RANDOM_OPS   = 1300;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = bfa_pkg::OP_ALLOC;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          ready_mode = 0;
  int          ready_hold = 0;
  int unsigned ready_cycle = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  bitmap_frame_allocator_unit #(
    .WORD_COUNT(WORD_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  bfa_tb_checker #(
    .WORD_COUNT(WORD_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count),
    .pending(pending)
  );

  // The result side switches between always ready, mostly ready, mostly
  // stalled and long alternating runs.
  always @(negedge clk) begin
    if (ready_cycle % 300 == 0) ready_mode = $urandom_range(0, 3);
    ready_cycle++;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (ready_hold == 0) begin
          ready_hold = $urandom_range(1, 16);
          out_tready <= ~out_tready;
        end else begin
          ready_hold--;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic [1:0] op, input logic [31:0] addr,
                         input logic [63:0] base, input logic [63:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {len, base, addr};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  function automatic void pick_region(output logic [63:0] base, output logic [63:0] len);
    logic [11:0] off;
    off = ($urandom_range(0, 1) == 0) ? 12'h000 : 12'($urandom);
    case ($urandom_range(0, 15))
      0: begin
        base = {$urandom, $urandom};
        len  = {$urandom, $urandom};
      end
      1, 2: begin
        // Near the top of the address space, so that the end often wraps.
        base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 32'h0001_0000));
        len  = 64'($urandom_range(0, 32'h0002_0000));
      end
      3: begin
        base = (64'($urandom_range(0, 4095)) << PAGE_SHIFT) | 64'(off);
        len  = {$urandom, $urandom};
      end
      default: begin
        base = (64'($urandom_range(0, 4100)) << PAGE_SHIFT) | 64'(off);
        len  = (64'($urandom_range(0, 40)) << PAGE_SHIFT) + 64'($urandom_range(0, 4095));
      end
    endcase
  endfunction

  initial begin
    logic [1:0]  op;
    logic [31:0] addr;
    logic [63:0] base;
    logic [63:0] len;
    int          pick;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE,        32'hFFFF_FFFF, 64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE,        32'h0100_0000, 64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE,        32'h00FF_FABC, 64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE,        32'h0000_0000, 64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE,        32'h0000_0FFF, 64'h0,     64'h0);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0,         64'h1001,  64'h2FFF);
    send_op(bfa_pkg::OP_RESERVE,     32'h0,         64'h0FFF,  64'h2);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0, 64'hFFFF_FFFF_FFFF_F000, 64'h2000);
    send_op(bfa_pkg::OP_RESERVE,     32'h0, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF);
    send_op(bfa_pkg::OP_RESERVE,     32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0,         64'h0,     64'hFFF);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0,         64'h0,     64'h0100_0000);
    send_op(bfa_pkg::OP_RESERVE,     32'h0,         64'h00FF_F000, 64'h0010_0000);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_RESERVE,     32'h0,         64'h0,     64'h0100_0000);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0,         64'h7F000, 64'h2000);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_ALLOC,       32'h0,         64'h0,     64'h0);
    send_op(bfa_pkg::OP_FREE_REGION, 32'h0,         64'h0,     64'hFFFF_FFFF_FFFF_FFFF);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      addr = $urandom;
      base = {$urandom, $urandom};
      len  = {$urandom, $urandom};
      if (pick < 40) begin
        op = bfa_pkg::OP_ALLOC;
      end else if (pick < 65) begin
        op = bfa_pkg::OP_FREE;
        if ($urandom_range(0, 4) != 0)
          addr = {8'h00, 12'($urandom_range(0, 4095)), 12'($urandom)};
      end else begin
        op = (pick < 82) ? bfa_pkg::OP_FREE_REGION : bfa_pkg::OP_RESERVE;
        pick_region(base, len);
      end
      send_op(op, addr, base, len);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
